FILE: hw/rtl/pfm_pkg.sv
// Shared types, constants and register codes of the pulse frequency meter.
`default_nettype none

package pfm_pkg;

	// Channel count and field widths
	localparam int CHANNELS       = 3;
	localparam int CH_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ELAPSED_W      = 14;
	localparam int MEAN_FRAC_BITS = 10;
	localparam int MEAN_W         = ELAPSED_W + MEAN_FRAC_BITS;
	localparam int ALPHA_W        = 16;
	localparam int COEF_W         = 16;
	localparam int FREQ_W         = 32;
	localparam int PIN_W          = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0   = 3'd2;

	localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = 14'd11000;
	localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 16'd39322;
	localparam logic [COEF_W-1:0]    COEF_RST    = 16'd256;

	// Shared multiplier: 17-bit weight by 24-bit operand
	localparam int MUL_A_W = ALPHA_W + 1;
	localparam int PROD_W  = MUL_A_W + MEAN_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int BLEND_W = ACC_W - ALPHA_W;
	localparam int MS_PER_S = 1000;
	localparam int MS_W     = 10;

	// Divider: numerator coef * 1000 << frac, radix-8 restoring steps
	localparam int NUM_W      = COEF_W + MS_W + MEAN_FRAC_BITS;
	localparam int DIV_STEP   = 3;
	localparam int DIV_CYCLES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
	localparam int CNT_W      = $clog2(DIV_CYCLES);
	localparam int CMP_W      = (DIV_W > FREQ_W) ? DIV_W : FREQ_W + 1;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [ELAPSED_W-1:0]             timeout;
		logic [ALPHA_W-1:0]               alpha;
		logic [CHANNELS-1:0][COEF_W-1:0]  coef;
	} cfg_t;

	// Classified tick, passed from front to back
	typedef struct packed {
		logic [CHANNELS-1:0]                 upd;
		logic [CHANNELS-1:0]                 live;
		logic [CHANNELS-1:0][ELAPSED_W-1:0]  dt;
	} rec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pfm_front.sv
// Front end: accepts ticks, tracks edges and elapsed counts, classifies each channel.
`default_nettype none

module pfm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pfm_pkg::PIN_W-1:0]     pin_levels,
	input  wire logic [pfm_pkg::ELAPSED_W-1:0] timeout,
	input  wire logic                          q_full,
	output logic                               q_push,
	output pfm_pkg::rec_t                      q_rec
);
	import pfm_pkg::*;

	logic [CHANNELS-1:0]                last_q;
	logic [CHANNELS-1:0][ELAPSED_W-1:0] elapsed_q;
	logic [CHANNELS-1:0][ELAPSED_W-1:0] elapsed_nx;
	logic [CHANNELS-1:0]                lvl;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign lvl      = CHANNELS'(pin_levels);

	// Advance counts, detect rising edges and classify each channel
	always_comb begin
		logic [ELAPSED_W:0]   e_inc;
		logic [ELAPSED_W-1:0] e_sat;
		logic                 rise;
		q_rec = '0;
		elapsed_nx = elapsed_q;
		for (int c = 0; c < CHANNELS; c++) begin
			e_inc = {1'b0, elapsed_q[c]} + (ELAPSED_W+1)'(1);
			e_sat = (e_inc >= {1'b0, timeout}) ? timeout : e_inc[ELAPSED_W-1:0];
			rise  = lvl[c] && !last_q[c];
			q_rec.upd[c] = rise && (e_sat < timeout);
			q_rec.dt[c]  = e_sat;
			elapsed_nx[c] = rise ? '0 : e_sat;
			q_rec.live[c] = elapsed_nx[c] < timeout;
		end
	end

	// Update channel state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			elapsed_q <= '0;
		end else if (q_push) begin
			last_q    <= lvl;
			elapsed_q <= elapsed_nx;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pfm_queue.sv
// Two-entry queue of classified ticks between front and back.
`default_nettype none

module pfm_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire pfm_pkg::rec_t push_rec,
	output logic         full,
	input  wire logic    pop,
	output logic         not_empty,
	output pfm_pkg::rec_t pop_rec
);
	import pfm_pkg::*;

	rec_t        mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_rec   = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'(do_pop ? 1 : 0);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pfm_back.sv
// Back end: per-channel mean update and frequency division, result register.
`default_nettype none

module pfm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pfm_pkg::cfg_t cfg,
	input  wire logic          q_valid,
	input  wire pfm_pkg::rec_t q_rec,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [pfm_pkg::CHANNELS-1:0][pfm_pkg::FREQ_W-1:0] freq
);
	import pfm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHAN  = 9'b000000010,
		S_M1    = 9'b000000100,
		S_M2    = 9'b000001000,
		S_SUM   = 9'b000010000,
		S_CHECK = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_QUOT  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t                           state_q;
	state_t                           state_nx;
	logic [CH_W-1:0]                  ch_q;
	logic [CNT_W-1:0]                 cnt_q;
	rec_t                             rec_q;
	logic [CHANNELS-1:0][MEAN_W-1:0]  mean_q;
	logic [CHANNELS-1:0][FREQ_W-1:0]  res_q;
	logic [CHANNELS-1:0][FREQ_W-1:0]  out_q;
	logic                             out_valid_q;
	logic [PROD_W-1:0]                prod_q;
	logic [ACC_W-1:0]                 acc_q;
	logic [DIV_W-1:0]                 num_q;
	logic [MEAN_W-1:0]                rem_q;

	logic [MEAN_W-1:0]                mean_rd;
	logic [MUL_A_W-1:0]               mul_a;
	logic [MEAN_W-1:0]                mul_b;
	logic [PROD_W-1:0]                mul_p;
	logic [ACC_W-1:0]                 sum;
	logic [BLEND_W-1:0]               blend;
	logic [MEAN_W-1:0]                mean_new;
	logic [DIV_W-1:0]                 num_nx;
	logic [MEAN_W-1:0]                rem_nx;
	logic [CMP_W-1:0]                 quot_ext;
	logic [FREQ_W-1:0]                quot_sat;
	logic                             last_ch;
	logic                             out_free;
	logic                             go_div;

	assign mean_rd   = mean_q[ch_q];
	assign last_ch   = ({1'b0, ch_q} == (CH_W+1)'(CHANNELS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign freq      = out_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign go_div    = rec_q.live[ch_q] && (mean_rd != '0);

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M1: begin
				mul_a = {1'b0, cfg.alpha};
				mul_b = {rec_q.dt[ch_q], {MEAN_FRAC_BITS{1'b0}}};
			end
			S_M2: begin
				mul_a = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, cfg.alpha};
				mul_b = mean_rd;
			end
			S_CHECK: begin
				mul_a = {1'b0, cfg.coef[ch_q]};
				mul_b = MEAN_W'(MS_PER_S);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Round, scale and saturate the blended mean
	assign sum      = acc_q + ACC_W'(prod_q);
	assign blend    = sum[ACC_W-1:ALPHA_W];
	assign mean_new = (blend > BLEND_W'({MEAN_W{1'b1}})) ? {MEAN_W{1'b1}}
		: blend[MEAN_W-1:0];

	// Take DIV_STEP quotient bits per cycle
	always_comb begin
		logic [MEAN_W:0] sh;
		logic            qbit;
		rem_nx = rem_q;
		num_nx = num_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			sh = {rem_nx, num_nx[DIV_W-1]};
			qbit = (sh >= {1'b0, mean_rd});
			if (qbit) begin
				sh = sh - {1'b0, mean_rd};
			end
			rem_nx = sh[MEAN_W-1:0];
			num_nx = {num_nx[DIV_W-2:0], qbit};
		end
	end

	// Saturate the quotient to the output width
	assign quot_ext = CMP_W'(num_q);
	assign quot_sat = (quot_ext > CMP_W'({FREQ_W{1'b1}})) ? {FREQ_W{1'b1}}
		: quot_ext[FREQ_W-1:0];

	// Sequence one tick through all channels
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (q_valid) state_nx = S_CHAN;
			S_CHAN:  state_nx = rec_q.upd[ch_q] ? S_M1 : S_CHECK;
			S_M1:    state_nx = S_M2;
			S_M2:    state_nx = S_SUM;
			S_SUM:   state_nx = S_CHECK;
			S_CHECK: begin
				if (go_div) begin
					state_nx = S_DIV;
				end else begin
					state_nx = last_ch ? S_OUT : S_CHAN;
				end
			end
			S_DIV:   if (cnt_q == CNT_W'(DIV_CYCLES - 1)) state_nx = S_QUOT;
			S_QUOT:  state_nx = last_ch ? S_OUT : S_CHAN;
			S_OUT:   if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Control state and channel means
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			cnt_q       <= '0;
			mean_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE) begin
				ch_q <= '0;
			end else if ((state_q == S_QUOT || (state_q == S_CHECK && !go_div)) && !last_ch) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_SUM) begin
				mean_q[ch_q] <= mean_new;
			end else if (state_q == S_CHECK && !go_div) begin
				mean_q[ch_q] <= '0;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rec;
		end
		if (state_q == S_M1 || state_q == S_M2) begin
			prod_q <= mul_p;
		end
		if (state_q == S_M2) begin
			acc_q <= ACC_W'(prod_q) + ACC_W'(1 << (ALPHA_W - 1));
		end
		if (state_q == S_CHECK) begin
			num_q <= DIV_W'({mul_p, {MEAN_FRAC_BITS{1'b0}}});
			rem_q <= '0;
			if (!go_div) begin
				res_q[ch_q] <= '0;
			end
		end
		if (state_q == S_DIV) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
		if (state_q == S_QUOT) begin
			res_q[ch_q] <= quot_sat;
		end
		if (state_q == S_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ch_q} < (CH_W+1)'(CHANNELS))
		else $error("channel index out of range");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= CNT_W'(DIV_CYCLES - 1))
		else $error("divider step count overran");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> mean_rd != '0)
		else $error("division by a zero mean");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result appeared outside the output step");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> state_q == S_OUT)
		else $error("sequencer left output step while result was held");

endmodule

`default_nettype wire

FILE: hw/rtl/pulse_frequency_meter.sv
// Top level of the three-channel pulse frequency meter.
//
// Usage: present one request per millisecond tick on in_valid / pin_levels
// (bit i is the level of channel i); it is taken when in_valid is high and
// in_stall is low. One result per request appears on out_valid with
// freq_ch0..freq_ch2 (unsigned Q24.8 Hz, 0 when a channel is idle) and is
// taken when out_stall is low. Registers are written through cfg_we,
// cfg_index and cfg_data: 0 timeout_ms, 1 alpha_q16, 2..4 coef_ch0..2.
// The front classifies a request in its accept cycle and puts it into a
// two-entry queue, so up to two requests are taken while the back is busy.
// The back handles channels one after another through one shared
// multiplier and a restoring divider that resolves 3 quotient bits per
// cycle. The work a request takes in the back is set by how many
// channels update their mean (steps M1, M2 and SUM) and divide (steps
// DIV and QUOT); the back takes its next request only when it is idle.
// Reset clears edge state, counts and means, and loads default registers.
// While out_stall is high the result holds; the back waits with its next
// result and the queue keeps accepting until it is full.
`default_nettype none

module pulse_frequency_meter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pfm_pkg::PIN_W-1:0]      pin_levels,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [pfm_pkg::FREQ_W-1:0]          freq_ch0,
	output logic [pfm_pkg::FREQ_W-1:0]          freq_ch1,
	output logic [pfm_pkg::FREQ_W-1:0]          freq_ch2,
	input  wire logic                           cfg_we,
	input  wire logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pfm_pkg::*;

	cfg_t                            cfg_q;
	rec_t                            push_rec;
	rec_t                            pop_rec;
	logic                            q_push;
	logic                            q_full;
	logic                            q_pop;
	logic                            q_valid;
	logic [CHANNELS-1:0][FREQ_W-1:0] freq;

	// Decode register writes, drop indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= TIMEOUT_RST;
			cfg_q.alpha   <= ALPHA_RST;
			for (int c = 0; c < CHANNELS; c++) begin
				cfg_q.coef[c] <= COEF_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[ELAPSED_W-1:0];
				REG_ALPHA:   cfg_q.alpha   <= cfg_data[ALPHA_W-1:0];
				default: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if ({1'b0, cfg_index} == (CFG_IDX_W+1)'(REG_COEF0) + (CFG_IDX_W+1)'(c)) begin
							cfg_q.coef[c] <= cfg_data[COEF_W-1:0];
						end
					end
				end
			endcase
		end
	end

	pfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_levels (pin_levels),
		.timeout    (cfg_q.timeout),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (push_rec)
	);

	pfm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_rec   (pop_rec)
	);

	pfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_rec     (pop_rec),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.freq      (freq)
	);

	assign freq_ch0 = freq[0];
	assign freq_ch1 = freq[1];
	assign freq_ch2 = freq[2];

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench of the pulse frequency meter: pulse trains in, per-tick frequencies checked.
`timescale 1ns / 1ps

module testbench;
	import pfm_pkg::*;

	localparam int          PHASES       = 12;
	localparam int          PHASE_TICKS  = 160;
	localparam int          HOLD_CYCLES  = 400;
	localparam int unsigned LIMIT        = 1_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_COEF1    = REG_COEF0 + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF2    = REG_COEF0 + 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_COEF0 + 3'd3;

	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

	typedef logic [CHANNELS-1:0][FREQ_W-1:0] reading_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [PIN_W-1:0]      pin_levels = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [FREQ_W-1:0]     freq_ch0;
	logic [FREQ_W-1:0]     freq_ch1;
	logic [FREQ_W-1:0]     freq_ch2;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// Register copies and channel state of the predictor
	logic [ELAPSED_W-1:0] cfg_timeout = TIMEOUT_RST;
	logic [ALPHA_W-1:0]   cfg_alpha   = ALPHA_RST;
	logic [COEF_W-1:0]    cfg_coef [CHANNELS] = '{default: COEF_RST};
	logic [CHANNELS-1:0]  lvl_prev    = '0;
	logic [ELAPSED_W-1:0] ms_since [CHANNELS] = '{default: '0};
	logic [MEAN_W-1:0]    avg_period [CHANNELS] = '{default: '0};

	logic [PIN_W-1:0] pin_ticks [$];
	reading_t         freq_expected [$];

	int          tx_idle_max = 8;
	int          rx_idle_max = 8;
	int          tx_wait;
	int          rx_wait;
	int          hold_left;
	bit          hold_req  = 1'b0;
	bit          hold_seen = 1'b0;
	int          errors    = 0;
	int unsigned cycle_count = 0;

	pulse_frequency_meter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_levels (pin_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.freq_ch0   (freq_ch0),
		.freq_ch1   (freq_ch1),
		.freq_ch2   (freq_ch2),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance every channel by one millisecond tick and queue the frequencies it reports
	function automatic void advance_meter(input logic [PIN_W-1:0] pins);
		logic [63:0] ms;
		logic [63:0] acc;
		logic [63:0] num;
		logic [63:0] quo;
		reading_t    r;
		for (int c = 0; c < CHANNELS; c++) begin
			ms = 64'(ms_since[c]) + 64'd1;
			if (ms >= 64'(cfg_timeout))
				ms = 64'(cfg_timeout);
			// rising edge: blend the new period into the mean if it is still valid
			if (pins[c] && !lvl_prev[c]) begin
				if (ms < 64'(cfg_timeout)) begin
					acc = 64'(cfg_alpha) * (ms << MEAN_FRAC_BITS)
					    + (64'd65536 - 64'(cfg_alpha)) * 64'(avg_period[c]) + 64'd32768;
					acc = acc >> ALPHA_W;
					avg_period[c] = (acc > 64'(MEAN_MAX)) ? MEAN_MAX : acc[MEAN_W-1:0];
				end
				ms = '0;
			end
			lvl_prev[c] = pins[c];
			ms_since[c] = ms[ELAPSED_W-1:0];
			r[c] = '0;
			// report scaled frequency, or drop the mean once the channel went idle
			if (ms_since[c] < cfg_timeout && avg_period[c] != '0) begin
				num = (64'(cfg_coef[c]) * MS_PER_S) << MEAN_FRAC_BITS;
				quo = num / 64'(avg_period[c]);
				r[c] = (quo > 64'(FREQ_MAX)) ? FREQ_MAX : quo[FREQ_W-1:0];
			end else begin
				avg_period[c] = '0;
			end
		end
		freq_expected.push_back(r);
	endfunction

	// Write one register and mirror it in the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_TIMEOUT: cfg_timeout = val[ELAPSED_W-1:0];
			REG_ALPHA: cfg_alpha = val[ALPHA_W-1:0];
			REG_COEF0, REG_COEF1, REG_COEF2: cfg_coef[idx - REG_COEF0] = val[COEF_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued tick is taken and every frequency has come back
	task automatic drain();
		do
			@(negedge clk);
		while (pin_ticks.size() != 0 || in_valid || freq_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Request driver: offer queued ticks, predict on each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			pin_levels <= '0;
			tx_wait    <= 0;
		end else begin
			if (in_valid && !in_stall)
				advance_meter(pin_levels);
			if (!in_valid || !in_stall) begin
				if (tx_wait != 0) begin
					tx_wait  <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (pin_ticks.size() != 0) begin
					pin_levels <= pin_ticks.pop_front();
					in_valid   <= 1'b1;
					tx_wait    <= $urandom_range(0, tx_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare with the oldest prediction, stall at random or for a long hold
	always @(posedge clk or negedge arst_n) begin : sink
		int       wait_n;
		int       hold_n;
		reading_t seen;
		reading_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else begin
			wait_n = (rx_wait != 0) ? rx_wait - 1 : 0;
			if (out_valid && !out_stall) begin
				seen = {freq_ch2, freq_ch1, freq_ch0};
				if (freq_expected.size() == 0) begin
					errors++;
					$error("result with no request pending");
				end else begin
					want = freq_expected.pop_front();
					for (int c = 0; c < CHANNELS; c++) begin
						if (seen[c] !== want[c]) begin
							errors++;
							$error("freq_ch%0d: expected %0d, actual %0d", c, want[c], seen[c]);
						end
					end
				end
				wait_n = $urandom_range(0, rx_idle_max);
			end
			hold_n = (hold_left != 0) ? hold_left - 1 : 0;
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_n = HOLD_CYCLES;
			end
			hold_left <= hold_n;
			rx_wait   <= wait_n;
			out_stall <= (hold_n != 0) || (wait_n != 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int               per [CHANNELS];
		int               hi [CHANNELS];
		int               pos [CHANNELS];
		int               tmo;
		int               span;
		logic [PIN_W-1:0] pins;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Defaults; the first edge after reset already gives a period
		@(negedge clk);
		pin_ticks = '{3'b111, 3'b000, 3'b001, 3'b110, 3'b000, 3'b111, 3'b000, 3'b010};
		drain();

		// One-ms timeout clears every mean
		write_reg(REG_TIMEOUT, 16'd1);
		@(negedge clk);
		pin_ticks = '{3'b000};
		drain();

		// Tiny mean from a small alpha: saturated, zero and borderline frequencies
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_ALPHA, 16'd32);
		write_reg(REG_COEF0, 16'hFFFF);
		write_reg(REG_COEF1, 16'd0);
		write_reg(REG_COEF2, 16'd4200);
		@(negedge clk);
		pin_ticks = '{3'b111, 3'b000, 3'b111, 3'b000};
		drain();

		// Zero alpha keeps the mean; writes past the last register are dropped
		write_reg(REG_ALPHA, 16'd0);
		for (int i = REG_SPARE_LO; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), 16'($urandom));
		@(negedge clk);
		pin_ticks = '{3'b111, 3'b000};
		drain();

		// Zero timeout: no period is ever valid
		write_reg(REG_TIMEOUT, 16'd0);
		@(negedge clk);
		pin_ticks = '{3'b111, 3'b000, 3'b111};
		drain();

		// Full alpha, longest timeout, then let the count run
		write_reg(REG_TIMEOUT, 16'h3FFF);
		write_reg(REG_ALPHA, 16'hFFFF);
		@(negedge clk);
		pin_ticks = '{3'b000, 3'b111, 3'b000, 3'b000, 3'b000};
		drain();

		// Lower the timeout under the running count
		write_reg(REG_TIMEOUT, 16'd2);
		@(negedge clk);
		pin_ticks = '{3'b000};

		// Random phases: new settings each time, jittered pulse trains with some noise
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p % 6)
				0: tmo = 16383;
				1: tmo = $urandom_range(2, 12);
				2: tmo = $urandom_range(13, 80);
				3: tmo = 1;
				4: tmo = $urandom_range(200, 16383);
				default: tmo = $urandom_range(20, 200);
			endcase
			write_reg(REG_TIMEOUT, {2'($urandom), 14'(tmo)});
			case (p % 5)
				0: write_reg(REG_ALPHA, 16'hFFFF);
				1: write_reg(REG_ALPHA, 16'd0);
				default: write_reg(REG_ALPHA, 16'($urandom));
			endcase
			for (int c = 0; c < CHANNELS; c++) begin
				case ($urandom_range(0, 7))
					0: write_reg(REG_COEF0 + 3'(c), 16'd0);
					1: write_reg(REG_COEF0 + 3'(c), 16'hFFFF);
					default: write_reg(REG_COEF0 + 3'(c), 16'($urandom));
				endcase
			end

			// Periods reach past the timeout when it is short
			span = (tmo > 40) ? 60 : tmo + tmo / 2 + 2;
			for (int c = 0; c < CHANNELS; c++) begin
				per[c] = $urandom_range(2, span);
				hi[c]  = $urandom_range(1, per[c] - 1);
				pos[c] = $urandom_range(0, per[c] - 1);
			end

			@(negedge clk);
			tx_idle_max = (p % 3 == 2) ? 0 : 8;
			rx_idle_max = (p % 4 == 0) ? 0 : 8;
			for (int t = 0; t < PHASE_TICKS; t++) begin
				if ($urandom_range(0, 19) == 0) begin
					pins = PIN_W'($urandom);
				end else begin
					for (int c = 0; c < CHANNELS; c++) begin
						pins[c] = (pos[c] < hi[c]);
						pos[c]++;
						if (pos[c] >= per[c]) begin
							pos[c] = 0;
							if ($urandom_range(0, 3) == 0) begin
								per[c] = $urandom_range(2, span);
								hi[c]  = $urandom_range(1, per[c] - 1);
							end
						end
					end
				end
				pin_ticks.push_back(pins);
			end

			// Back up the block with a long result hold while requests keep coming
			if (p == 2)
				hold_req = ~hold_req;
		end

		drain();
		repeat (64) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/pfm_pkg.sv
hw/rtl/pfm_front.sv
hw/rtl/pfm_queue.sv
hw/rtl/pfm_back.sv
hw/rtl/pulse_frequency_meter.sv
sim/testbench.sv
